// ===== src/scl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and keyword tables of the source character lexer.
package scl_pkg;

    // Depth of the token-job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    localparam int KW_COUNT = 4;

    // Token kinds
    localparam logic [3:0] KIND_IDENT  = 4'd0;
    localparam logic [3:0] KIND_STAR   = 4'd1;
    localparam logic [3:0] KIND_COLON  = 4'd2;
    localparam logic [3:0] KIND_EQUAL  = 4'd3;
    localparam logic [3:0] KIND_LBRACE = 4'd4;
    localparam logic [3:0] KIND_LPAREN = 4'd5;
    localparam logic [3:0] KIND_MINUS  = 4'd6;
    localparam logic [3:0] KIND_PLUS   = 4'd7;
    localparam logic [3:0] KIND_RBRACE = 4'd8;
    localparam logic [3:0] KIND_RPAREN = 4'd9;
    localparam logic [3:0] KIND_SEMI   = 4'd10;
    localparam logic [3:0] KIND_SLASH  = 4'd11;
    localparam logic [3:0] KIND_FN     = 4'd12;
    localparam logic [3:0] KIND_PUB    = 4'd13;
    localparam logic [3:0] KIND_RETURN = 4'd14;
    localparam logic [3:0] KIND_VAR    = 4'd15;

    // Result status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    // Saturation point of the identifier length
    localparam logic [2:0] LEN_MAX = 3'd7;

    // Keyword lengths, in keyword order fn, pub, return, var
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd2, 3'd3, 3'd6, 3'd3};
    localparam logic [3:0] KW_KIND [KW_COUNT] = '{KIND_FN, KIND_PUB, KIND_RETURN, KIND_VAR};

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } t_in_beat;

    typedef struct packed {
        logic [3:0] token_kind;
        logic       status;
        logic       last_of_run;
    } t_out_beat;

    // All tokens caused by one input character
    typedef struct packed {
        logic      two;
        t_out_beat first;
        t_out_beat second;
    } t_job;

    typedef struct packed {
        logic push;
        t_job job;
    } t_push;

    // Character of keyword idx at position pos, zero past its end
    function automatic logic [7:0] kw_char(input logic [1:0] idx, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case ({idx, pos})
            {2'd0, 3'd0}: ch = "f";
            {2'd0, 3'd1}: ch = "n";
            {2'd1, 3'd0}: ch = "p";
            {2'd1, 3'd1}: ch = "u";
            {2'd1, 3'd2}: ch = "b";
            {2'd2, 3'd0}: ch = "r";
            {2'd2, 3'd1}: ch = "e";
            {2'd2, 3'd2}: ch = "t";
            {2'd2, 3'd3}: ch = "u";
            {2'd2, 3'd4}: ch = "r";
            {2'd2, 3'd5}: ch = "n";
            {2'd3, 3'd0}: ch = "v";
            {2'd3, 3'd1}: ch = "a";
            {2'd3, 3'd2}: ch = "r";
            default:      ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Punctuation kind, KIND_IDENT when not punctuation
    function automatic logic [3:0] punct_kind(input logic [7:0] c);
        logic [3:0] k;
        k = KIND_IDENT;
        case (c)
            "*":     k = KIND_STAR;
            ":":     k = KIND_COLON;
            "=":     k = KIND_EQUAL;
            "{":     k = KIND_LBRACE;
            "(":     k = KIND_LPAREN;
            "-":     k = KIND_MINUS;
            "+":     k = KIND_PLUS;
            "}":     k = KIND_RBRACE;
            ")":     k = KIND_RPAREN;
            ";":     k = KIND_SEMI;
            "/":     k = KIND_SLASH;
            default: k = KIND_IDENT;
        endcase
        return k;
    endfunction

    // Narrow the keyword candidates by one more character
    function automatic logic [KW_COUNT-1:0] kw_keep(input logic [KW_COUNT-1:0] cand,
                                                    input logic [2:0] len,
                                                    input logic [7:0] c);
        logic [KW_COUNT-1:0] keep;
        keep = '0;
        for (int i = 0; i < KW_COUNT; i++) begin
            keep[i] = cand[i] && (len < KW_LEN[i]) && (kw_char(2'(i), len) == c);
        end
        return keep;
    endfunction

    // Kind of a closed identifier: first keyword that matches fully
    function automatic logic [3:0] close_kind(input logic [KW_COUNT-1:0] cand,
                                              input logic [2:0] len);
        logic [3:0] k;
        k = KIND_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            if (cand[i] && len == KW_LEN[i]) begin
                k = KW_KIND[i];
            end
        end
        return k;
    endfunction

endpackage

// ===== src/scl_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts characters, tracks lexer state and builds token jobs.
module scl_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  scl_pkg::t_in_beat i_in,
    input  logic              i_full,
    output scl_pkg::t_push    o_push
);

    localparam logic [1:0] MODE_BEGIN = 2'd0;
    localparam logic [1:0] MODE_IDENT = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;

    logic [1:0]                   r_mode, n_mode;
    logic [scl_pkg::KW_COUNT-1:0] r_cand, n_cand;
    logic [2:0]                   r_len, n_len;

    logic       w_accept;
    logic [7:0] w_c;
    logic [3:0] w_pk;
    logic       w_letter, w_digit, w_space, w_known;
    logic [scl_pkg::KW_COUNT-1:0] w_take_cand, w_cand_src;
    logic [2:0] w_take_len, w_len_src;
    logic [1:0] w_cnt;
    logic [3:0] w_kind0, w_kind1;
    logic       w_status0;

    assign o_in_stall = i_full;
    assign w_accept   = i_in_valid && !i_full;

    // Classify the character
    assign w_c      = i_in.char_code;
    assign w_pk     = scl_pkg::punct_kind(w_c);
    assign w_letter = (w_c >= "a" && w_c <= "z") || (w_c >= "A" && w_c <= "Z");
    assign w_digit  = (w_c >= "0" && w_c <= "9");
    assign w_space  = (w_c == " ") || (w_c == 8'h0D) || (w_c == 8'h0A);
    assign w_known  = w_letter || w_digit || w_space || (w_pk != scl_pkg::KIND_IDENT);

    // Take one identifier character; a fresh identifier starts from all candidates
    assign w_cand_src  = (r_mode == MODE_BEGIN) ? '1 : r_cand;
    assign w_len_src   = (r_mode == MODE_BEGIN) ? 3'd0 : r_len;
    assign w_take_cand = scl_pkg::kw_keep(w_cand_src, w_len_src, w_c);
    assign w_take_len  = (w_len_src < scl_pkg::LEN_MAX) ? w_len_src + 3'd1 : w_len_src;

    // Work out next state and the tokens of this character
    always_comb begin
        n_mode    = r_mode;
        n_cand    = r_cand;
        n_len     = r_len;
        w_cnt     = 2'd0;
        w_kind0   = scl_pkg::KIND_IDENT;
        w_kind1   = scl_pkg::KIND_IDENT;
        w_status0 = scl_pkg::STATUS_OK;
        if (r_mode == MODE_BEGIN || r_mode == MODE_IDENT) begin
            if (!w_known) begin
                w_cnt     = 2'd1;
                w_status0 = scl_pkg::STATUS_ERROR;
                n_mode    = MODE_STOP;
                n_cand    = '0;
                n_len     = 3'd0;
            end else begin
                if (r_mode == MODE_BEGIN) begin
                    if (w_pk != scl_pkg::KIND_IDENT) begin
                        w_cnt   = 2'd1;
                        w_kind0 = w_pk;
                    end else if (w_letter) begin
                        n_cand = w_take_cand;
                        n_len  = w_take_len;
                        n_mode = MODE_IDENT;
                    end
                end else begin
                    if (w_letter || w_digit) begin
                        n_cand = w_take_cand;
                        n_len  = w_take_len;
                    end else begin
                        w_cnt   = 2'd1;
                        w_kind0 = scl_pkg::close_kind(r_cand, r_len);
                        if (w_pk != scl_pkg::KIND_IDENT) begin
                            w_cnt   = 2'd2;
                            w_kind1 = w_pk;
                        end
                        n_mode = MODE_BEGIN;
                    end
                end
                // Flush a pending identifier at end of input
                if (i_in.end_of_input && n_mode == MODE_IDENT) begin
                    w_cnt   = 2'd1;
                    w_kind0 = scl_pkg::close_kind(n_cand, n_len);
                    n_mode  = MODE_BEGIN;
                end
            end
        end
    end

    // Pack the job for the queue
    always_comb begin
        o_push.push                   = w_accept && (w_cnt != 2'd0);
        o_push.job.two                = (w_cnt == 2'd2);
        o_push.job.first.token_kind   = w_kind0;
        o_push.job.first.status       = w_status0;
        o_push.job.first.last_of_run  = (w_cnt != 2'd2);
        o_push.job.second.token_kind  = w_kind1;
        o_push.job.second.status      = scl_pkg::STATUS_OK;
        o_push.job.second.last_of_run = 1'b1;
    end

    // Advance lexer state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BEGIN;
            r_cand <= '0;
            r_len  <= 3'd0;
        end else if (w_accept) begin
            r_mode <= n_mode;
            r_cand <= n_cand;
            r_len  <= n_len;
        end
    end

endmodule

// ===== src/scl_queue.sv =====
`timescale 1ns / 1ps
// Short queue of token jobs between the front and back ends.
module scl_queue #(
    parameter int DEPTH = scl_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  scl_pkg::t_push i_push,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output scl_pkg::t_job  o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    scl_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push.push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push.push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== src/scl_back.sv =====
`timescale 1ns / 1ps
// Back end: splits token jobs into single output beats behind an output register.
module scl_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  scl_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output scl_pkg::t_out_beat o_out
);

    logic               r_out_valid;
    scl_pkg::t_out_beat r_out;
    logic               r_pend_valid;
    scl_pkg::t_out_beat r_pend;
    logic               w_free;

    assign w_free      = !r_out_valid || !i_out_stall;
    assign o_pop       = w_free && !r_pend_valid && !i_empty;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Load the output register from the pending beat first, then the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (w_free) begin
            if (r_pend_valid) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else begin
                r_out_valid  <= !i_empty;
                r_pend_valid <= !i_empty && i_job.two;
            end
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_free) begin
            if (r_pend_valid) begin
                r_out <= r_pend;
            end else begin
                r_out  <= i_job.first;
                r_pend <= i_job.second;
            end
        end
    end

endmodule

// ===== src/source_char_lexer.sv =====
`timescale 1ns / 1ps
// Top level of the source character lexer: front end, job queue, back end.
// A token reaches the output register by way of the job queue after its character is accepted.
// Throughput: one character per cycle while the job queue is not full; the output gives
// one token per unstalled cycle, and an identifier closed by punctuation gives two tokens.
// Input stalls only while the job queue is full.
// Reset (i_rst_n low, synchronous) returns the lexer to begin mode and empties the queue.
module source_char_lexer #(
    parameter int QUEUE_DEPTH = scl_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  scl_pkg::t_in_beat  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output scl_pkg::t_out_beat o_out
);

    scl_pkg::t_push w_push;
    scl_pkg::t_job  w_job;
    logic           w_full, w_empty, w_pop;

    scl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_full     (w_full),
        .o_push     (w_push)
    );

    scl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_job   (w_job)
    );

    scl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_job       (w_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // Never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push.push && w_full))
        else $error("job pushed into full queue");

    // Never pop an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("job popped from empty queue");

    // An error beat closes its run and carries the identifier kind
    a_error_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == scl_pkg::STATUS_ERROR) |->
        (o_out.last_of_run && o_out.token_kind == scl_pkg::KIND_IDENT))
        else $error("malformed error beat");

    // A two-token job pushes a punctuation kind second
    a_second_punct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.push && w_push.job.two) |->
        (w_push.job.second.token_kind != scl_pkg::KIND_IDENT &&
         !w_push.job.first.last_of_run))
        else $error("bad two-token job");

endmodule
